// ===== rtl/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared sizes, codes, types and the symbol decoder of the brainfuck machine.
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

  // storage sizes
  localparam int TAPE_CELLS    = 32768;
  localparam int PROGRAM_DEPTH = 1024;
  localparam int INPUT_DEPTH   = 16;

  localparam int TAPE_AW = $clog2(TAPE_CELLS);
  localparam int PROG_AW = $clog2(PROGRAM_DEPTH);
  localparam int PLEN_W  = $clog2(PROGRAM_DEPTH + 1);
  localparam int IQ_AW   = $clog2(INPUT_DEPTH);
  localparam int IQ_CW   = $clog2(INPUT_DEPTH + 1);

  // fixed payload widths
  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int CELL_PTR_W = 15;
  localparam int PC_W       = 11;

  // program symbols
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
  localparam logic [BYTE_W-1:0] EOF_BYTE = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUEUE  = 2'd1,
    CMD_EXEC   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_ENDED      = 3'd1,
    ST_UNMATCHED  = 3'd2,
    ST_PROG_FULL  = 3'd3,
    ST_INPUT_FULL = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    OP_RIGHT,
    OP_LEFT,
    OP_INC,
    OP_DEC,
    OP_OUT,
    OP_IN,
    OP_OPEN,
    OP_CLOSE,
    OP_NONE
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_EXEC,
    S_LOAD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    in_ready;
    logic    take;
    logic    append;
    logic    queue;
    logic    clear;
    logic    fetch;
    logic    cell_wr;
    logic    ptr_move;
    logic    pc_inc;
    logic    scan_start;
    logic    scan_rd;
    logic    scan_chk;
    logic    scan_jump;
    logic    clr_wr;
    logic    set_st;
    status_t st;
    logic    emit;
    logic    out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic prog_full;
    logic in_full;
    logic pc_end;
    op_t  op;
    logic cell_zero;
    logic scan_end;
    logic scan_hit;
    logic clr_last;
    logic out_free;
  } sts_t;

  function automatic op_t decode_op(input logic [BYTE_W-1:0] c);
    op_t o;
    case (c)
      CH_RIGHT: o = OP_RIGHT;
      CH_LEFT:  o = OP_LEFT;
      CH_INC:   o = OP_INC;
      CH_DEC:   o = OP_DEC;
      CH_OUT:   o = OP_OUT;
      CH_IN:    o = OP_IN;
      CH_OPEN:  o = OP_OPEN;
      CH_CLOSE: o = OP_CLOSE;
      default:  o = OP_NONE;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bfm_if.sv =====
// ----------------------------------------------------------------------------
// bfm_if
// Valid/ready channels of the brainfuck machine: command in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfm_in_if import bfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface bfm_out_if import bfm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  out_valid;
  logic [BYTE_W-1:0]     out_byte;
  logic [STATUS_W-1:0]   status;
  logic [CELL_PTR_W-1:0] cell_pointer;
  logic [PC_W-1:0]       program_counter;
  logic [BYTE_W-1:0]     cell_value;

  modport source (output valid, output out_valid, output out_byte, output status,
                  output cell_pointer, output program_counter, output cell_value,
                  input ready);
  modport sink   (input valid, input out_valid, input out_byte, input status,
                  input cell_pointer, input program_counter, input cell_value,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/brainfuck_machine_step.sv =====
// ----------------------------------------------------------------------------
// brainfuck_machine_step
// Brainfuck machine with a cleared byte tape, program store and input queue.
// ----------------------------------------------------------------------------
//
// channel   direction  payload
// in_chan   sink       command, symbol
// out_chan  source     out_valid, out_byte, status, cell_pointer,
//                      program_counter, cell_value
//
// one item at a time: append, queue and clear pass from dispatch straight to
// the result state; an execute adds the execute state, a pointer move also a
// load state (tape re-read through the single registered read port); a
// bracket jump adds a read and a check state for every program symbol the
// scan reads from the program store, and one more read if no match is found
// after reset a clearing pass zeroes all 32768 tape cells, one cell a cycle,
// during which no item is taken
// a finished result sits in the output register, so the next item is taken
// while it waits; only a second result stalls on out_chan.ready
// ----------------------------------------------------------------------------
`default_nettype none

module brainfuck_machine_step import bfm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bfm_in_if.sink     in_chan,
  bfm_out_if.source  out_chan
);

  // command and status between sequencer and datapath
  ctl_t ctl;
  sts_t sts;

  bfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .sts      (sts),
    .ctl      (ctl)
  );

  // ready only while idle, the transfer latches command and symbol
  assign in_chan.ready = ctl.in_ready;

  bfm_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .in_command          (in_chan.command),
    .in_symbol           (in_chan.symbol),
    .out_ready           (out_chan.ready),
    .out_vld             (out_chan.valid),
    .out_flag            (out_chan.out_valid),
    .out_byte            (out_chan.out_byte),
    .out_status          (out_chan.status),
    .out_cell_pointer    (out_chan.cell_pointer),
    .out_program_counter (out_chan.program_counter),
    .out_cell_value      (out_chan.cell_value)
  );

endmodule

`default_nettype wire

// ===== rtl/bfm_datapath.sv =====
// ----------------------------------------------------------------------------
// bfm_datapath
// Tape and program memories, input queue, machine registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_datapath import bfm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctl_t                  ctl,
  output sts_t                       sts,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [BYTE_W-1:0]     in_symbol,
  input  wire logic                  out_ready,
  output logic                       out_vld,
  output logic                       out_flag,
  output logic [BYTE_W-1:0]          out_byte,
  output logic [STATUS_W-1:0]        out_status,
  output logic [CELL_PTR_W-1:0]      out_cell_pointer,
  output logic [PC_W-1:0]            out_program_counter,
  output logic [BYTE_W-1:0]          out_cell_value
);

  // memories
  logic [BYTE_W-1:0] tape_mem [TAPE_CELLS];
  logic [BYTE_W-1:0] prog_mem [PROGRAM_DEPTH];
  logic [BYTE_W-1:0] iq_r     [INPUT_DEPTH];

  logic [BYTE_W-1:0]  tape_rdata_r;
  logic [BYTE_W-1:0]  prog_rdata_r;

  // machine state
  cmd_t               cmd_r;
  logic [BYTE_W-1:0]  sym_r;
  logic [PLEN_W-1:0]  len_r,   len_nxt;
  logic [PLEN_W-1:0]  pc_r,    pc_nxt;
  logic [TAPE_AW-1:0] dp_r,    dp_nxt;
  logic [BYTE_W-1:0]  cell_r,  cell_nxt;
  logic [IQ_CW-1:0]   cnt_r,   cnt_nxt;
  logic [IQ_AW-1:0]   head_r,  head_nxt;
  logic [IQ_AW-1:0]   tail_r,  tail_nxt;
  logic [TAPE_AW-1:0] clr_r;
  logic               load_q;

  // bracket scan
  logic               dir_r;
  logic [PLEN_W-1:0]  scan_r,  scan_nxt;
  logic [PLEN_W-1:0]  depth_r, depth_nxt;

  // result
  status_t            st_r;
  logic               emit_r;
  logic               ovld_r;

  op_t                op;
  logic               pop;
  logic [BYTE_W-1:0]  cell_new;
  logic               tape_we;
  logic [TAPE_AW-1:0] tape_waddr;
  logic [BYTE_W-1:0]  tape_wdata;
  logic [PROG_AW-1:0] prog_raddr;

  assign op  = decode_op(prog_rdata_r);
  assign pop = ctl.cell_wr && (op == OP_IN) && (cnt_r != '0);

  // new cell value for the writing instructions
  always_comb begin
    case (op)
      OP_INC:  cell_new = cell_r + 1'b1;
      OP_DEC:  cell_new = cell_r - 1'b1;
      OP_IN:   cell_new = (cnt_r != '0) ? iq_r[head_r] : EOF_BYTE;
      default: cell_new = cell_r;
    endcase
  end

  // pointer wraps at the tape size
  always_comb begin
    dp_nxt = dp_r;
    if (ctl.ptr_move) begin
      if (op == OP_RIGHT) begin
        dp_nxt = (dp_r == TAPE_AW'(TAPE_CELLS - 1)) ? '0 : dp_r + 1'b1;
      end else begin
        dp_nxt = (dp_r == '0) ? TAPE_AW'(TAPE_CELLS - 1) : dp_r - 1'b1;
      end
    end
  end

  always_comb begin
    len_nxt  = len_r;
    pc_nxt   = pc_r;
    cell_nxt = cell_r;
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.append) begin
      len_nxt = len_r + 1'b1;
    end
    if (ctl.clear) begin
      len_nxt = '0;
      pc_nxt  = '0;
    end
    if (ctl.queue) begin
      tail_nxt = (tail_r == IQ_AW'(INPUT_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      cnt_nxt  = cnt_r + 1'b1;
    end
    if (pop) begin
      head_nxt = (head_r == IQ_AW'(INPUT_DEPTH - 1)) ? '0 : head_r + 1'b1;
      cnt_nxt  = cnt_r - 1'b1;
    end
    if (ctl.pc_inc) begin
      pc_nxt = pc_r + 1'b1;
    end
    if (ctl.scan_jump) begin
      pc_nxt = scan_r + 1'b1;
    end
    if (ctl.cell_wr) begin
      cell_nxt = cell_new;
    end
    // the load state takes the freshly read cell into the cache
    if (load_q) begin
      cell_nxt = tape_rdata_r;
    end
  end

  // scan index and nesting depth
  always_comb begin
    scan_nxt  = scan_r;
    depth_nxt = depth_r;
    if (ctl.scan_start) begin
      scan_nxt  = (op == OP_CLOSE) ? pc_r : pc_r + 1'b1;
      depth_nxt = PLEN_W'(1);
    end
    if (ctl.scan_rd && dir_r) begin
      scan_nxt = scan_r - 1'b1;
    end
    if (ctl.scan_chk) begin
      if (!dir_r) begin
        scan_nxt = scan_r + 1'b1;
      end
      if ((op == OP_CLOSE && !dir_r) || (op == OP_OPEN && dir_r)) begin
        depth_nxt = depth_r - 1'b1;
      end else if ((op == OP_OPEN && !dir_r) || (op == OP_CLOSE && dir_r)) begin
        depth_nxt = depth_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      pc_r   <= '0;
      dp_r   <= '0;
      cell_r <= '0;
      cnt_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
      clr_r  <= '0;
      ovld_r <= 1'b0;
      dir_r  <= 1'b0;
      load_q <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      pc_r   <= pc_nxt;
      dp_r   <= dp_nxt;
      cell_r <= cell_nxt;
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      load_q <= ctl.ptr_move;
      if (ctl.clr_wr) begin
        clr_r <= clr_r + 1'b1;
      end
      if (ctl.out_load) begin
        ovld_r <= 1'b1;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
      if (ctl.scan_start) begin
        dir_r <= (op == OP_CLOSE);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r  <= scan_nxt;
    depth_r <= depth_nxt;
    if (ctl.take) begin
      cmd_r  <= cmd_t'(in_command);
      sym_r  <= in_symbol;
      st_r   <= ST_OK;
      emit_r <= 1'b0;
    end
    if (ctl.set_st) begin
      st_r <= ctl.st;
    end
    if (ctl.emit) begin
      emit_r <= 1'b1;
    end
    if (ctl.queue) begin
      iq_r[tail_r] <= sym_r;
    end
    if (ctl.out_load) begin
      out_flag            <= emit_r;
      out_byte            <= emit_r ? cell_r : '0;
      out_status          <= STATUS_W'(st_r);
      out_cell_pointer    <= CELL_PTR_W'(dp_r);
      out_program_counter <= PC_W'(pc_r);
      out_cell_value      <= cell_r;
    end
  end

  // tape: one write port, one registered read port
  assign tape_we    = ctl.clr_wr || ctl.cell_wr;
  assign tape_waddr = ctl.clr_wr ? clr_r : dp_r;
  assign tape_wdata = ctl.clr_wr ? '0 : cell_new;

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    tape_rdata_r <= tape_mem[dp_nxt];
  end

  // program store
  assign prog_raddr = ctl.fetch ? pc_r[PROG_AW-1:0]
                    : (dir_r ? PROG_AW'(scan_r - 1'b1) : scan_r[PROG_AW-1:0]);

  always_ff @(posedge clk) begin
    if (ctl.append) begin
      prog_mem[len_r[PROG_AW-1:0]] <= sym_r;
    end
    prog_rdata_r <= prog_mem[prog_raddr];
  end

  // status to the sequencer
  always_comb begin
    sts.cmd       = cmd_r;
    sts.prog_full = (len_r == PLEN_W'(PROGRAM_DEPTH));
    sts.in_full   = (cnt_r == IQ_CW'(INPUT_DEPTH));
    sts.pc_end    = (pc_r >= len_r);
    sts.op        = op;
    sts.cell_zero = (cell_r == '0);
    sts.scan_end  = dir_r ? (scan_r == '0) : (scan_r >= len_r);
    sts.scan_hit  = (depth_r == PLEN_W'(1))
                 && ((op == OP_CLOSE && !dir_r) || (op == OP_OPEN && dir_r));
    sts.clr_last  = (clr_r == TAPE_AW'(TAPE_CELLS - 1));
    sts.out_free  = !ovld_r || out_ready;
  end

  assign out_vld = ovld_r;

  a_iq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IQ_CW'(INPUT_DEPTH))
    else $error("input queue count beyond its depth");

  a_pc_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= len_r)
    else $error("instruction index beyond program length");

  a_dp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dp_r <= TAPE_AW'(TAPE_CELLS - 1))
    else $error("data pointer off the tape");

  a_no_pop_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.queue && pop))
    else $error("queue push and pop in one cycle");

endmodule

`default_nettype wire

// ===== rtl/bfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfm_ctrl
// Sequencer of the brainfuck machine: dispatch, execute, bracket scan, result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_ctrl import bfm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts.cmd == CMD_EXEC && !sts.pc_end) state_nxt = S_EXEC;
        else                                      state_nxt = S_RESULT;
      end
      S_EXEC: begin
        case (sts.op)
          OP_RIGHT, OP_LEFT: state_nxt = S_LOAD;
          OP_OPEN:  state_nxt = sts.cell_zero  ? S_SCAN_RD : S_RESULT;
          OP_CLOSE: state_nxt = !sts.cell_zero ? S_SCAN_RD : S_RESULT;
          default:  state_nxt = S_RESULT;
        endcase
      end
      S_LOAD: state_nxt = S_RESULT;
      S_SCAN_RD: begin
        state_nxt = sts.scan_end ? S_RESULT : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        state_nxt = sts.scan_hit ? S_RESULT : S_SCAN_RD;
      end
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    ctl    = '0;
    ctl.st = ST_OK;
    case (state_r)
      S_CLEAR: ctl.clr_wr = 1'b1;
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.take     = in_valid;
      end
      S_DISPATCH: begin
        case (sts.cmd)
          CMD_APPEND: begin
            if (sts.prog_full) begin
              ctl.set_st = 1'b1;
              ctl.st     = ST_PROG_FULL;
            end else begin
              ctl.append = 1'b1;
            end
          end
          CMD_QUEUE: begin
            if (sts.in_full) begin
              ctl.set_st = 1'b1;
              ctl.st     = ST_INPUT_FULL;
            end else begin
              ctl.queue = 1'b1;
            end
          end
          CMD_CLEAR: ctl.clear = 1'b1;
          default: begin
            if (sts.pc_end) begin
              ctl.set_st = 1'b1;
              ctl.st     = ST_ENDED;
            end else begin
              ctl.fetch = 1'b1;
            end
          end
        endcase
      end
      S_EXEC: begin
        case (sts.op)
          OP_INC, OP_DEC, OP_IN: begin
            ctl.cell_wr = 1'b1;
            ctl.pc_inc  = 1'b1;
          end
          OP_OUT: begin
            ctl.emit   = 1'b1;
            ctl.pc_inc = 1'b1;
          end
          OP_RIGHT, OP_LEFT: begin
            ctl.ptr_move = 1'b1;
            ctl.pc_inc   = 1'b1;
          end
          OP_OPEN: begin
            ctl.scan_start = sts.cell_zero;
            ctl.pc_inc     = !sts.cell_zero;
          end
          OP_CLOSE: begin
            ctl.scan_start = !sts.cell_zero;
            ctl.pc_inc     = sts.cell_zero;
          end
          default: ctl.pc_inc = 1'b1;
        endcase
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          ctl.set_st = 1'b1;
          ctl.st     = ST_UNMATCHED;
        end else begin
          ctl.scan_rd = 1'b1;
        end
      end
      S_SCAN_CHK: begin
        ctl.scan_chk  = 1'b1;
        ctl.scan_jump = sts.scan_hit;
      end
      S_RESULT: ctl.out_load = sts.out_free;
      default: ;
    endcase
  end

  a_scan_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD || state_r == S_SCAN_CHK) |-> sts.cmd == CMD_EXEC)
    else $error("bracket scan outside an execute item");

endmodule

`default_nettype wire

// ===== bench/bfm_step_check.sv =====
// ----------------------------------------------------------------------------
// bfm_step_check
// Watches both channels of the brainfuck machine, works out the result of
// every command transfer from its own copy of tape, program store and input
// queue, and compares each result transfer with the oldest one outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_step_check import bfm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bfm_in_if         in_mon,
  bfm_out_if        out_mon,
  output int        errors,
  output int        outstanding
);

  typedef struct packed {
    logic                  out_valid;
    logic [BYTE_W-1:0]     out_byte;
    status_t               status;
    logic [CELL_PTR_W-1:0] cell_pointer;
    logic [PC_W-1:0]       program_counter;
    logic [BYTE_W-1:0]     cell_value;
  } step_result_t;

  // machine state as the commands leave it
  logic [BYTE_W-1:0]  tape      [TAPE_CELLS];
  logic [BYTE_W-1:0]  prog      [PROGRAM_DEPTH];
  logic [PLEN_W-1:0]  prog_len;
  logic [PLEN_W-1:0]  pc;
  logic [TAPE_AW-1:0] dp;
  logic [BYTE_W-1:0]  inq       [INPUT_DEPTH];
  logic [IQ_CW-1:0]   inq_count;
  logic [IQ_AW-1:0]   inq_head;
  logic [IQ_AW-1:0]   inq_tail;

  step_result_t pending_results [$];
  int unsigned  n_results;

  function automatic step_result_t bf_step(input cmd_t cmd, input logic [BYTE_W-1:0] sym);
    step_result_t      r;
    logic [PLEN_W-1:0] nxt;
    int                i;
    int                depth;
    int                hit;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_APPEND: begin
        if (prog_len < PROGRAM_DEPTH) begin
          prog[prog_len] = sym;
          prog_len = prog_len + 1'b1;
        end else begin
          r.status = ST_PROG_FULL;
        end
      end
      CMD_QUEUE: begin
        if (inq_count < INPUT_DEPTH) begin
          inq[inq_tail] = sym;
          inq_tail  = IQ_AW'((inq_tail + 1) % INPUT_DEPTH);
          inq_count = inq_count + 1'b1;
        end else begin
          r.status = ST_INPUT_FULL;
        end
      end
      CMD_CLEAR: begin
        prog_len = '0;
        pc       = '0;
      end
      default: begin
        if (pc >= prog_len) begin
          r.status = ST_ENDED;
        end else begin
          nxt = pc + 1'b1;
          case (prog[pc])
            CH_RIGHT: dp = (dp == TAPE_CELLS - 1) ? '0 : dp + 1'b1;
            CH_LEFT:  dp = (dp == 0) ? TAPE_AW'(TAPE_CELLS - 1) : dp - 1'b1;
            CH_INC:   tape[dp] = tape[dp] + 1'b1;
            CH_DEC:   tape[dp] = tape[dp] - 1'b1;
            CH_OUT: begin
              r.out_valid = 1'b1;
              r.out_byte  = tape[dp];
            end
            CH_IN: begin
              if (inq_count != 0) begin
                tape[dp]  = inq[inq_head];
                inq_head  = IQ_AW'((inq_head + 1) % INPUT_DEPTH);
                inq_count = inq_count - 1'b1;
              end else begin
                tape[dp] = EOF_BYTE;
              end
            end
            CH_OPEN: begin
              if (tape[dp] == 0) begin
                depth = 1;
                hit   = -1;
                for (i = int'(pc) + 1; i < int'(prog_len) && hit < 0; i++) begin
                  if (prog[i] == CH_OPEN) depth++;
                  if (prog[i] == CH_CLOSE) begin
                    depth--;
                    if (depth == 0) hit = i;
                  end
                end
                if (hit < 0) begin
                  r.status = ST_UNMATCHED;
                  nxt = pc;
                end else begin
                  nxt = PLEN_W'(hit + 1);
                end
              end
            end
            CH_CLOSE: begin
              if (tape[dp] != 0) begin
                depth = 1;
                hit   = -1;
                for (i = int'(pc) - 1; i >= 0 && hit < 0; i--) begin
                  if (prog[i] == CH_CLOSE) depth++;
                  if (prog[i] == CH_OPEN) begin
                    depth--;
                    if (depth == 0) hit = i;
                  end
                end
                if (hit < 0) begin
                  r.status = ST_UNMATCHED;
                  nxt = pc;
                end else begin
                  nxt = PLEN_W'(hit + 1);
                end
              end
            end
            default: ;
          endcase
          pc = nxt;
        end
      end
    endcase
    r.cell_pointer    = dp;
    r.program_counter = pc;
    r.cell_value      = tape[dp];
    return r;
  endfunction

  task automatic report(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h expected %0h", n_results, name, got, want));
  endtask

  task automatic check_result();
    step_result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result %0d arrived with nothing outstanding", n_results));
    end else begin
      want = pending_results.pop_front();
      check_field("out_valid", out_mon.out_valid, want.out_valid);
      check_field("out_byte", out_mon.out_byte, want.out_byte);
      check_field("status", out_mon.status, want.status);
      check_field("cell_pointer", out_mon.cell_pointer, want.cell_pointer);
      check_field("program_counter", out_mon.program_counter, want.program_counter);
      check_field("cell_value", out_mon.cell_value, want.cell_value);
    end
    n_results++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAPE_CELLS; k++) tape[k] = '0;
      prog_len  = '0;
      pc        = '0;
      dp        = '0;
      inq_count = '0;
      inq_head  = '0;
      inq_tail  = '0;
      n_results = 0;
      pending_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(bf_step(cmd_t'(in_mon.command), in_mon.symbol));
    end
    outstanding <= pending_results.size();
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the brainfuck machine: directed instruction and
// status cases, then random programs with queued input and noise, with
// idling on both channels. Results are checked by bfm_step_check.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bfm_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 820;
  localparam int LONG_HOLD    = 400;
  localparam int LIMIT_CYCLES = 1000000;

  typedef logic [BYTE_W-1:0] sym_q_t [$];

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bfm_in_if  in_chan ();
  bfm_out_if out_chan ();

  int errors;
  int outstanding;

  // no idling on either side once set
  bit quiet    = 1'b0;
  // asks the result side for one long hold-off, cleared by that side
  bit hold_req = 1'b0;

  int items_sent = 0;
  int n_progs    = 0;

  brainfuck_machine_step u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  bfm_step_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #HALF_PERIOD clk = ~clk;

  // one command transfer, with an optional idle burst in front of it;
  // valid is left high so back-to-back items need no second assignment
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] sym);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.command <= cmd;
    in_chan.symbol  <= sym;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // any command with any symbol
  task automatic noise();
    send(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
  endtask

  // short program, brackets balanced unless broken; the odd filler symbol
  // may itself be a stray bracket
  task automatic make_program(output sym_q_t p, input bit broken);
    int               len;
    int               depth;
    logic [BYTE_W-1:0] c;
    p     = {};
    len   = $urandom_range(1, 20);
    depth = 0;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: c = CH_RIGHT;
        1: c = CH_LEFT;
        2: c = CH_INC;
        3: c = CH_DEC;
        4: c = CH_OUT;
        5: c = CH_IN;
        6: begin
          c = CH_OPEN;
          depth++;
        end
        7: begin
          if (depth > 0) begin
            c = CH_CLOSE;
            depth--;
          end else begin
            c = CH_INC;
          end
        end
        8: c = CH_DEC;
        default: c = BYTE_W'($urandom_range(0, 255));
      endcase
      p.push_back(c);
    end
    while (depth > 0) begin
      p.push_back(CH_CLOSE);
      depth--;
    end
    if (broken) begin
      // unmatched close at the front or unmatched open at the back
      if ($urandom_range(0, 1)) p.push_front(CH_CLOSE);
      else p.push_back(CH_OPEN);
    end
  endtask

  // result side: random hold-off bursts, one long hold on request
  initial begin : result_side
    int gap;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        gap = $urandom_range(1, 11);
        repeat (gap) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    sym_q_t            prog;
    int                rand_goal;
    int                nq;
    int                nexec;

    in_chan.valid   <= 1'b0;
    in_chan.command <= CMD_APPEND;
    in_chan.symbol  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----------------------------------------------------
    // the first transfer waits out the tape clearing pass
    send(CMD_EXEC, 8'h00);          // empty program: ended
    send(CMD_APPEND, CH_IN);
    send(CMD_EXEC, 8'hFF);          // read from an empty queue gives 255
    send(CMD_APPEND, CH_OUT);
    send(CMD_EXEC, 8'h00);          // output 255
    send(CMD_APPEND, CH_INC);
    send(CMD_EXEC, 8'h00);          // 255 + 1 wraps to 0
    send(CMD_APPEND, CH_DEC);
    send(CMD_EXEC, 8'h00);          // 0 - 1 wraps to 255
    send(CMD_APPEND, CH_LEFT);
    send(CMD_EXEC, 8'h00);          // pointer wraps down to the top cell
    send(CMD_APPEND, CH_RIGHT);
    send(CMD_EXEC, 8'h00);          // and back up to cell 0
    send(CMD_APPEND, 8'h00);
    send(CMD_EXEC, 8'h00);          // non-instruction symbols only advance
    send(CMD_APPEND, 8'hFF);
    send(CMD_EXEC, 8'hFF);
    send(CMD_QUEUE, 8'hFF);
    send(CMD_QUEUE, 8'h00);
    send(CMD_CLEAR, 8'hFF);
    send(CMD_APPEND, CH_CLOSE);
    send(CMD_EXEC, 8'h00);          // cell is 255: backward jump, no match
    send(CMD_CLEAR, 8'h00);
    send(CMD_APPEND, CH_IN);
    send(CMD_APPEND, CH_IN);
    send(CMD_APPEND, CH_OPEN);
    send(CMD_EXEC, 8'h00);          // queue gives ff
    send(CMD_EXEC, 8'h00);          // queue gives 00, queue now empty
    send(CMD_EXEC, 8'h00);          // cell is 0: forward jump, no match

    // ---- random programs --------------------------------------------------
    rand_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < rand_goal) begin
      if (items_sent > rand_goal - 120) quiet = 1'b1;
      if (n_progs == 3) begin
        // sender pauses until all results are in, then the result side
        // holds off while the next program keeps arriving
        drain();
        hold_req = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        drain();
      end

      send(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)));
      nq = ($urandom_range(0, 7) == 0) ? INPUT_DEPTH + 2 : $urandom_range(0, 4);
      repeat (nq) send(CMD_QUEUE, BYTE_W'($urandom_range(0, 255)));

      make_program(prog, $urandom_range(0, 5) == 0);
      foreach (prog[i]) begin
        send(CMD_APPEND, prog[i]);
        if ($urandom_range(0, 24) == 0) noise();
      end

      nexec = $urandom_range(prog.size(), 3 * prog.size() + 4);
      repeat (nexec) begin
        send(CMD_EXEC, BYTE_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) == 0) noise();
      end
      n_progs++;
    end

    // ---- wind down ---------------------------------------------------------
    drain();
    repeat (16) @(posedge clk);

    $display("covered %0d command transfers: directed instruction and status cases,",
             items_sent);
    $display("and %0d random programs with queued input, noise and output stalls",
             n_progs);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("timeout with %0d results outstanding", outstanding);
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
